[src/bellman_ford_shortest_path_macros.svh]
// Assertion helpers for the design files that check their own logic.
`ifndef BELLMAN_FORD_SHORTEST_PATH_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATH_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BFSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BFSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bfsp_pkg.sv]
package bfsp_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 1024;

  localparam int VTX_W    = 6;
  localparam int VCNT_W   = 7;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;
  localparam int SUM_W    = DIST_W + 1;
  localparam int EDGE_AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W   = $clog2(MAX_EDGES + 1);
  localparam int VCNT_RST = MAX_VERTICES;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 1'b1;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_RUN = 1'b1;

  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

  typedef struct packed {
    logic [VTX_W-1:0]           src;
    logic [VTX_W-1:0]           dst;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] dist_val;
    logic [VTX_W-1:0]         pred;
  } vtx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SRC,
    ST_SRC_LD,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_RELAX,
    ST_NEG_RD,
    ST_NEG_CHK,
    ST_NEG_SRC,
    ST_NEG_CMP,
    ST_OUT_RD,
    ST_OUT_WR
  } state_t;

endpackage

[src/bellman_ford_shortest_path.sv]
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_func, in_src_vertex, in_dst_vertex, in_weight
// out      output     out_valid/out_stall vertex, distance, reachable, predecessor,
//                                        has_pred, negative_cycle, last
// cfg      input      cfg_we             cfg_index, cfg_wdata (no read-back)
//
// Edge loads are accepted only while idle, and may then follow each other every cycle.
// A run item holds in_stall high while the search walks the edge memory: per pass,
// each source is tested for reachability, and each reachable source loads its distance,
// reads and checks every stored edge and relaxes each edge leaving it. The cycle check
// reads each edge and compares endpoint distances; results are read and then emitted.
// Reset is synchronous and clears all control state and the per-vertex flags.
// A stalled result holds in the output register; the search itself never waits on it.
`include "bellman_ford_shortest_path_macros.svh"

module bellman_ford_shortest_path
  import bfsp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [VTX_W-1:0]           in_src_vertex,
  input  logic [VTX_W-1:0]           in_dst_vertex,
  input  logic signed [WEIGHT_W-1:0] in_weight,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [VTX_W-1:0]           out_vertex,
  output logic signed [DIST_W-1:0]   out_distance,
  output logic                       out_reachable,
  output logic [VTX_W-1:0]           out_predecessor,
  output logic                       out_has_pred,
  output logic                       out_negative_cycle,
  output logic                       out_last,

  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  // Control state.
  state_t state_r, state_nxt;

  logic [VCNT_W-1:0] vcount_r, vcount_nxt;
  logic [VTX_W-1:0]  start_r, start_nxt;
  logic [ECNT_W-1:0] edge_cnt_r, edge_cnt_nxt;
  logic [ECNT_W-1:0] e_r, e_nxt;
  logic [VTX_W-1:0]  u_r, u_nxt;
  logic [VTX_W-1:0]  v_r, v_nxt;
  logic [VTX_W-1:0]  pass_r, pass_nxt;
  logic              changed_r, changed_nxt;
  logic              neg_r, neg_nxt;
  logic [MAX_VERTICES-1:0] reach_r, reach_nxt;
  logic [MAX_VERTICES-1:0] pv_r, pv_nxt;

  // Datapath registers.
  logic signed [DIST_W-1:0] dist_u_r, dist_u_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0]         out_vertex_r, out_vertex_nxt;
  logic signed [DIST_W-1:0] out_distance_r, out_distance_nxt;
  logic                     out_reachable_r, out_reachable_nxt;
  logic [VTX_W-1:0]         out_pred_r, out_pred_nxt;
  logic                     out_has_pred_r, out_has_pred_nxt;
  logic                     out_neg_r, out_neg_nxt;
  logic                     out_last_r, out_last_nxt;

  // Memory ports.
  logic               edge_we;
  edge_t              edge_wdata, edge_rdata;
  logic               vram_we;
  logic [VTX_W-1:0]   vram_waddr, vram_raddr;
  vtx_t               vram_wdata, vram_rdata;

  // Derived control.
  logic [VCNT_W-1:0] n_eff;
  logic              start_ok;
  logic              in_acc;
  logic              out_free;
  logic              u_last, v_last, e_last;
  logic              pass_stop;
  logic              changed_now;
  logic              edge_match;
  logic              neg_skip;
  logic              improve;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DIST_W-1:0] nd;
  logic              neg_less;
  state_t            neg_entry, pass_end_tgt, edge_next_tgt, neg_next_tgt, u_next_tgt;

  // Vertex count zero acts as one, and counts above the vertex table as the full table.
  always_comb begin
    priority if (vcount_r == '0) begin
      n_eff = VCNT_W'(1);
    end else if (vcount_r > VCNT_W'(MAX_VERTICES)) begin
      n_eff = VCNT_W'(MAX_VERTICES);
    end else begin
      n_eff = vcount_r;
    end
  end

  assign start_ok = VCNT_W'(start_r) < n_eff;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign u_last   = (VCNT_W'(u_r) + VCNT_W'(1)) == n_eff;
  assign v_last   = (VCNT_W'(v_r) + VCNT_W'(1)) == n_eff;
  assign e_last   = (e_r + ECNT_W'(1)) == edge_cnt_r;

  // Relaxation sum is exact; the stored distance saturates to the 32-bit range.
  assign sum = SUM_W'(dist_u_r) + SUM_W'(edge_rdata.weight);
  always_comb begin
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      nd = sum[SUM_W-1] ? DIST_MIN : DIST_MAX;
    end else begin
      nd = $signed(sum[DIST_W-1:0]);
    end
  end

  assign edge_match = (edge_rdata.src == u_r) && (VCNT_W'(edge_rdata.dst) < n_eff);
  assign improve    = !reach_r[edge_rdata.dst] || (nd < vram_rdata.dist_val);
  assign neg_skip   = (VCNT_W'(edge_rdata.src) >= n_eff) ||
                      (VCNT_W'(edge_rdata.dst) >= n_eff) || !reach_r[edge_rdata.src];
  assign neg_less   = sum < SUM_W'(vram_rdata.dist_val);

  // A pass stops the search when nothing changed or when all n-1 passes are done.
  assign changed_now = changed_r || ((state_r == ST_RELAX) && improve);
  assign pass_stop   = !changed_now || ((VCNT_W'(pass_r) + VCNT_W'(2)) >= n_eff);

  assign neg_entry     = (edge_cnt_r == '0) ? ST_OUT_RD : ST_NEG_RD;
  assign pass_end_tgt  = pass_stop ? neg_entry : ST_SRC;
  assign u_next_tgt    = u_last ? pass_end_tgt : ST_SRC;
  assign edge_next_tgt = e_last ? u_next_tgt : ST_EDGE_RD;
  assign neg_next_tgt  = e_last ? ST_OUT_RD : ST_NEG_RD;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_func == FUNC_RUN)) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        priority if (!start_ok) begin
          state_nxt = ST_OUT_RD;
        end else if (n_eff == VCNT_W'(1)) begin
          state_nxt = neg_entry;
        end else begin
          state_nxt = ST_SRC;
        end
      end
      ST_SRC:      state_nxt = reach_r[u_r] ? ST_SRC_LD : u_next_tgt;
      ST_SRC_LD:   state_nxt = (edge_cnt_r == '0) ? u_next_tgt : ST_EDGE_RD;
      ST_EDGE_RD:  state_nxt = ST_EDGE_CHK;
      ST_EDGE_CHK: state_nxt = edge_match ? ST_RELAX : edge_next_tgt;
      ST_RELAX:    state_nxt = edge_next_tgt;
      ST_NEG_RD:   state_nxt = ST_NEG_CHK;
      ST_NEG_CHK: begin
        priority if (neg_skip) begin
          state_nxt = neg_next_tgt;
        end else if (!reach_r[edge_rdata.dst]) begin
          state_nxt = ST_OUT_RD;
        end else begin
          state_nxt = ST_NEG_SRC;
        end
      end
      ST_NEG_SRC:  state_nxt = ST_NEG_CMP;
      ST_NEG_CMP:  state_nxt = neg_less ? ST_OUT_RD : neg_next_tgt;
      ST_OUT_RD:   state_nxt = ST_OUT_WR;
      ST_OUT_WR: begin
        if (out_free) begin
          state_nxt = v_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  // Memory addressing. The vertex memory read address is chosen so that its data
  // lands in the following state. While a result waits, the same entry is read
  // again so that its data stays in place.
  assign edge_we    = in_acc && (in_func == FUNC_ADD) && (edge_cnt_r < ECNT_W'(MAX_EDGES));
  assign edge_wdata = '{src: in_src_vertex, dst: in_dst_vertex, weight: in_weight};

  always_comb begin
    unique case (state_r)
      ST_EDGE_CHK:          vram_raddr = edge_rdata.dst;
      ST_NEG_CHK:           vram_raddr = edge_rdata.src;
      ST_NEG_SRC:           vram_raddr = edge_rdata.dst;
      ST_OUT_RD, ST_OUT_WR: vram_raddr = v_r;
      default:              vram_raddr = u_r;
    endcase
  end

  // Datapath and counters.
  always_comb begin
    vcount_nxt   = vcount_r;
    start_nxt    = start_r;
    edge_cnt_nxt = edge_cnt_r;
    e_nxt        = e_r;
    u_nxt        = u_r;
    v_nxt        = v_r;
    pass_nxt     = pass_r;
    changed_nxt  = changed_r;
    neg_nxt      = neg_r;
    reach_nxt    = reach_r;
    pv_nxt       = pv_r;
    dist_u_nxt   = dist_u_r;
    vram_we      = 1'b0;
    vram_waddr   = start_r;
    vram_wdata   = '{dist_val: '0, pred: '0};

    out_valid_nxt     = out_valid_r && out_stall;
    out_vertex_nxt    = out_vertex_r;
    out_distance_nxt  = out_distance_r;
    out_reachable_nxt = out_reachable_r;
    out_pred_nxt      = out_pred_r;
    out_has_pred_nxt  = out_has_pred_r;
    out_neg_nxt       = out_neg_r;
    out_last_nxt      = out_last_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT: vcount_nxt = cfg_wdata[VCNT_W-1:0];
        CFG_START_VERTEX: start_nxt  = cfg_wdata[VTX_W-1:0];
        default:          vcount_nxt = vcount_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (edge_we) begin
          edge_cnt_nxt = edge_cnt_r + ECNT_W'(1);
        end
        if (in_acc && (in_func == FUNC_RUN)) begin
          reach_nxt          = '0;
          reach_nxt[start_r] = start_ok;
          pv_nxt             = '0;
          neg_nxt            = 1'b0;
          changed_nxt        = 1'b0;
          u_nxt              = '0;
          v_nxt              = '0;
          e_nxt              = '0;
          pass_nxt           = '0;
        end
      end
      ST_INIT: begin
        // The start vertex begins at distance zero.
        vram_we = start_ok;
      end
      ST_SRC, ST_SRC_LD, ST_EDGE_CHK, ST_RELAX: begin
        logic adv_e;
        logic adv_u;
        adv_e = 1'b0;
        adv_u = 1'b0;
        unique case (state_r)
          ST_SRC: begin
            adv_u = !reach_r[u_r];
          end
          ST_SRC_LD: begin
            dist_u_nxt = vram_rdata.dist_val;
            e_nxt      = '0;
            adv_u      = (edge_cnt_r == '0);
          end
          ST_EDGE_CHK: begin
            adv_e = !edge_match;
          end
          default: begin
            if (improve) begin
              vram_we                    = 1'b1;
              vram_waddr                 = edge_rdata.dst;
              vram_wdata                 = '{dist_val: nd, pred: u_r};
              reach_nxt[edge_rdata.dst]  = 1'b1;
              pv_nxt[edge_rdata.dst]     = 1'b1;
              changed_nxt                = 1'b1;
              // A self-loop moves the distance that later edges of this source use.
              if (edge_rdata.dst == u_r) begin
                dist_u_nxt = nd;
              end
            end
            adv_e = 1'b1;
          end
        endcase
        if (adv_e) begin
          if (e_last) begin
            adv_u = 1'b1;
          end else begin
            e_nxt = e_r + ECNT_W'(1);
          end
        end
        if (adv_u) begin
          e_nxt = '0;
          if (u_last) begin
            u_nxt       = '0;
            pass_nxt    = pass_r + VTX_W'(1);
            changed_nxt = 1'b0;
          end else begin
            u_nxt = u_r + VTX_W'(1);
          end
        end
      end
      ST_NEG_CHK: begin
        priority if (neg_skip) begin
          if (!e_last) begin
            e_nxt = e_r + ECNT_W'(1);
          end
        end else if (!reach_r[edge_rdata.dst]) begin
          neg_nxt = 1'b1;
        end else begin
          neg_nxt = neg_r;
        end
      end
      ST_NEG_SRC: begin
        dist_u_nxt = vram_rdata.dist_val;
      end
      ST_NEG_CMP: begin
        if (neg_less) begin
          neg_nxt = 1'b1;
        end else if (!e_last) begin
          e_nxt = e_r + ECNT_W'(1);
        end
      end
      ST_OUT_WR: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_vertex_nxt    = v_r;
          out_distance_nxt  = reach_r[v_r] ? vram_rdata.dist_val : '0;
          out_reachable_nxt = reach_r[v_r];
          out_pred_nxt      = pv_r[v_r] ? vram_rdata.pred : '0;
          out_has_pred_nxt  = pv_r[v_r];
          out_neg_nxt       = neg_r;
          out_last_nxt      = v_last;
          if (v_last) begin
            // Every run empties the edge store.
            edge_cnt_nxt = '0;
          end else begin
            v_nxt = v_r + VTX_W'(1);
          end
        end
      end
      default: begin
        e_nxt = e_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= VCNT_W'(VCNT_RST);
      start_r     <= '0;
      edge_cnt_r  <= '0;
      e_r         <= '0;
      u_r         <= '0;
      v_r         <= '0;
      pass_r      <= '0;
      changed_r   <= 1'b0;
      neg_r       <= 1'b0;
      reach_r     <= '0;
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      start_r     <= start_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      e_r         <= e_nxt;
      u_r         <= u_nxt;
      v_r         <= v_nxt;
      pass_r      <= pass_nxt;
      changed_r   <= changed_nxt;
      neg_r       <= neg_nxt;
      reach_r     <= reach_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_u_r        <= dist_u_nxt;
    out_vertex_r    <= out_vertex_nxt;
    out_distance_r  <= out_distance_nxt;
    out_reachable_r <= out_reachable_nxt;
    out_pred_r      <= out_pred_nxt;
    out_has_pred_r  <= out_has_pred_nxt;
    out_neg_r       <= out_neg_nxt;
    out_last_r      <= out_last_nxt;
  end

  // Edge store: source, destination and weight in one word per edge, in load order.
  bfsp_ram #(
    .WIDTH($bits(edge_t)),
    .DEPTH(MAX_EDGES)
  ) u_edge_ram (
    .clk  (clk),
    .we   (edge_we),
    .waddr(edge_cnt_r[EDGE_AW-1:0]),
    .wdata(edge_wdata),
    .raddr(e_r[EDGE_AW-1:0]),
    .rdata(edge_rdata)
  );

  // Vertex store: distance and predecessor; validity lives in the flag registers.
  bfsp_ram #(
    .WIDTH($bits(vtx_t)),
    .DEPTH(MAX_VERTICES)
  ) u_vtx_ram (
    .clk  (clk),
    .we   (vram_we),
    .waddr(vram_waddr),
    .wdata(vram_wdata),
    .raddr(vram_raddr),
    .rdata(vram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_vertex         = out_vertex_r;
  assign out_distance       = out_distance_r;
  assign out_reachable      = out_reachable_r;
  assign out_predecessor    = out_pred_r;
  assign out_has_pred       = out_has_pred_r;
  assign out_negative_cycle = out_neg_r;
  assign out_last           = out_last_r;

  // The edge counter never runs past the store depth.
  `BFSP_ASSERT_IMP(a_edge_cnt_bound, 1'b1, edge_cnt_r <= ECNT_W'(MAX_EDGES), "edge count past store depth")
  // The final result of a run names the last vertex in use.
  `BFSP_ASSERT_IMP(a_last_vertex, out_valid_r && out_last_r, (VCNT_W'(out_vertex_r) + VCNT_W'(1)) == n_eff, "last flag on wrong vertex")
  // Handing over the final result returns to idle with an empty edge store.
  `BFSP_ASSERT_NXT(a_run_clears_store, (state_r == ST_OUT_WR) && out_free && v_last, (edge_cnt_r == '0) && (state_r == ST_IDLE), "run did not empty the edge store")
  // A new result appears only from the emit step.
  `BFSP_ASSERT_IMP(a_out_from_emit, $rose(out_valid_r), $past(state_r) == ST_OUT_WR, "result raised outside emit")

endmodule

[src/bfsp_ram.sv]
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[tb/sv/shortest_path_monitor.sv]
`timescale 1ns / 1ps

// Watches the edge, result and register ports of the shortest-path engine. It keeps
// its own copy of the edge list and registers, solves each search when the run item
// is accepted, and compares every accepted result with the oldest one still owed.
module shortest_path_monitor
  import bfsp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_func,
  input  logic [VTX_W-1:0]           in_src_vertex,
  input  logic [VTX_W-1:0]           in_dst_vertex,
  input  logic signed [WEIGHT_W-1:0] in_weight,

  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [VTX_W-1:0]           out_vertex,
  input  logic signed [DIST_W-1:0]   out_distance,
  input  logic                       out_reachable,
  input  logic [VTX_W-1:0]           out_predecessor,
  input  logic                       out_has_pred,
  input  logic                       out_negative_cycle,
  input  logic                       out_last,

  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,

  output int                         fail_count,
  output int                         results_pending
);

  typedef struct {
    logic [VTX_W-1:0]         vertex;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic [VTX_W-1:0]         predecessor;
    logic                     has_pred;
    logic                     negative_cycle;
    logic                     last;
  } vertex_result_t;

  logic [VTX_W-1:0]           edge_from [MAX_EDGES];
  logic [VTX_W-1:0]           edge_to   [MAX_EDGES];
  logic signed [WEIGHT_W-1:0] edge_cost [MAX_EDGES];
  int                         edge_total;
  logic [VCNT_W-1:0]          vertex_count_reg;
  logic [VTX_W-1:0]           start_vertex_reg;
  vertex_result_t             owed_results [$];

  // Solves the stored graph from the start vertex and queues one result per vertex.
  task automatic solve_shortest_paths();
    int                       n, u, v, e, k, pass_idx;
    int                       relax_order [$];
    bit                       changed, neg;
    longint                   sum;
    logic signed [DIST_W-1:0] nd;
    logic signed [DIST_W-1:0] best_dist [MAX_VERTICES];
    logic [VTX_W-1:0]         pred      [MAX_VERTICES];
    bit                       reach     [MAX_VERTICES];
    bit                       pred_ok   [MAX_VERTICES];
    vertex_result_t           r;

    n = vertex_count_reg;
    if (n < 1) n = 1;
    if (n > MAX_VERTICES) n = MAX_VERTICES;
    for (v = 0; v < MAX_VERTICES; v++) begin
      best_dist[v] = '0;
      pred[v]      = '0;
      reach[v]     = 1'b0;
      pred_ok[v]   = 1'b0;
    end
    neg = 1'b0;

    if (start_vertex_reg < n) begin
      reach[start_vertex_reg] = 1'b1;
      // A pass walks sources in ascending order and each source's edges in load
      // order, so a stable sort of the usable edges by source gives the same walk.
      for (u = 0; u < n; u++) begin
        for (e = 0; e < edge_total; e++) begin
          if (edge_from[e] == u && edge_to[e] < n) relax_order.push_back(e);
        end
      end
      for (pass_idx = 0; pass_idx + 1 < n; pass_idx++) begin
        changed = 1'b0;
        foreach (relax_order[k]) begin
          e = relax_order[k];
          u = edge_from[e];
          v = edge_to[e];
          if (reach[u]) begin
            sum = longint'(best_dist[u]) + longint'(edge_cost[e]);
            if (sum < longint'(DIST_MIN)) nd = DIST_MIN;
            else if (sum > longint'(DIST_MAX)) nd = DIST_MAX;
            else nd = sum[DIST_W-1:0];
            if (!reach[v] || nd < best_dist[v]) begin
              best_dist[v] = nd;
              reach[v]     = 1'b1;
              pred[v]      = u[VTX_W-1:0];
              pred_ok[v]   = 1'b1;
              changed      = 1'b1;
            end
          end
        end
        if (!changed) break;
      end
      // The cycle check uses the exact sum, not the saturated one.
      for (e = 0; e < edge_total && !neg; e++) begin
        u = edge_from[e];
        v = edge_to[e];
        if (u < n && v < n && reach[u]) begin
          if (!reach[v]) neg = 1'b1;
          else if (longint'(best_dist[u]) + longint'(edge_cost[e]) <
                   longint'(best_dist[v]))
            neg = 1'b1;
        end
      end
    end

    for (v = 0; v < n; v++) begin
      r.vertex         = v[VTX_W-1:0];
      r.distance       = reach[v] ? best_dist[v] : '0;
      r.reachable      = reach[v];
      r.predecessor    = pred_ok[v] ? pred[v] : '0;
      r.has_pred       = pred_ok[v];
      r.negative_cycle = neg;
      r.last           = (v == n - 1);
      owed_results.push_back(r);
    end
    edge_total = 0;
  endtask

  task automatic check_field(string name, int vtx, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch at vertex %0d: expected %0d, got %0d",
             name, vtx, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  task automatic compare_result();
    vertex_result_t want;
    if (owed_results.size() == 0) begin
      $error("result for vertex %0d arrived with none expected", out_vertex);
      fail_count++;
    end else begin
      want = owed_results.pop_front();
      check_field("vertex", want.vertex, 64'(want.vertex), 64'(out_vertex));
      check_field("distance", want.vertex, 64'(want.distance), 64'(out_distance));
      check_field("reachable", want.vertex, 64'(want.reachable), 64'(out_reachable));
      check_field("predecessor", want.vertex, 64'(want.predecessor),
                  64'(out_predecessor));
      check_field("has_pred", want.vertex, 64'(want.has_pred), 64'(out_has_pred));
      check_field("negative_cycle", want.vertex, 64'(want.negative_cycle),
                  64'(out_negative_cycle));
      check_field("last", want.vertex, 64'(want.last), 64'(out_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      edge_total       = 0;
      vertex_count_reg = VCNT_W'(VCNT_RST);
      start_vertex_reg = '0;
      owed_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_VERTEX_COUNT) vertex_count_reg = cfg_wdata[VCNT_W-1:0];
        else if (cfg_index == CFG_START_VERTEX) start_vertex_reg = cfg_wdata[VTX_W-1:0];
      end
      if (out_valid && !out_stall) compare_result();
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_RUN) begin
          solve_shortest_paths();
        end else if (edge_total < MAX_EDGES) begin
          edge_from[edge_total] = in_src_vertex;
          edge_to[edge_total]   = in_dst_vertex;
          edge_cost[edge_total] = in_weight;
          edge_total++;
        end
      end
    end
    results_pending = owed_results.size();
  end

endmodule

[tb/sv/bellman_ford_shortest_path_test.sv]
`timescale 1ns / 1ps

// Top of the shortest-path engine test. This module only makes stimulus and gives
// the verdict; the monitor beside the engine predicts and checks every result.
module bellman_ford_shortest_path_test;
  import bfsp_pkg::*;

  // The slowest plausible run stays far below this limit, so only a hung engine
  // ever reaches it.
  localparam int CYCLE_LIMIT  = 3_000_000;
  // Items offered over the whole test, directed and random together.
  localparam int TOTAL_ITEMS  = 480;
  // Length of the one long receiver hold-off, long enough for the engine to
  // finish its search and back up against the stalled result port.
  localparam int HOLD_CYCLES  = 400;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_func;
  logic [VTX_W-1:0]           in_src_vertex;
  logic [VTX_W-1:0]           in_dst_vertex;
  logic signed [WEIGHT_W-1:0] in_weight;
  logic                       out_valid;
  logic                       out_stall;
  logic [VTX_W-1:0]           out_vertex;
  logic signed [DIST_W-1:0]   out_distance;
  logic                       out_reachable;
  logic [VTX_W-1:0]           out_predecessor;
  logic                       out_has_pred;
  logic                       out_negative_cycle;
  logic                       out_last;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;

  int fail_count;
  int results_pending;
  int cycles_run;
  int burst_left;
  int items_sent;
  bit hold_armed;

  bellman_ford_shortest_path u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_src_vertex      (in_src_vertex),
    .in_dst_vertex      (in_dst_vertex),
    .in_weight          (in_weight),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_vertex         (out_vertex),
    .out_distance       (out_distance),
    .out_reachable      (out_reachable),
    .out_predecessor    (out_predecessor),
    .out_has_pred       (out_has_pred),
    .out_negative_cycle (out_negative_cycle),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  shortest_path_monitor u_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_src_vertex      (in_src_vertex),
    .in_dst_vertex      (in_dst_vertex),
    .in_weight          (in_weight),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_vertex         (out_vertex),
    .out_distance       (out_distance),
    .out_reachable      (out_reachable),
    .out_predecessor    (out_predecessor),
    .out_has_pred       (out_has_pred),
    .out_negative_cycle (out_negative_cycle),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .results_pending    (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("bellman_ford_shortest_path_test NOT OK");
      $finish;
    end
  end

  // Result-side back-pressure. The receiver switches between stretches with
  // no stall, light stall and heavy stall. Once the random part has begun it
  // also holds off for a long stretch on the first result that it sees while
  // an item is on offer, and the sender keeps offering, so the engine backs
  // up and stalls its input.
  initial begin
    int mode_left;
    int stall_pct;
    int hold_left;
    bit hold_done;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (hold_armed && !hold_done && out_valid && in_valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 200);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        mode_left--;
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offers one item and returns at the falling edge after it was taken. The
  // sender works in bursts: between bursts valid may drop for a random gap, and
  // within a burst items follow back to back with valid left high.
  task automatic offer_item(logic func, logic [VTX_W-1:0] src, logic [VTX_W-1:0] dst,
                            logic signed [WEIGHT_W-1:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid      = 1'b1;
    in_func       = func;
    in_src_vertex = src;
    in_dst_vertex = dst;
    in_weight     = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic add_edge(int src, int dst, int w);
    offer_item(FUNC_ADD, src[VTX_W-1:0], dst[VTX_W-1:0], w[WEIGHT_W-1:0]);
  endtask

  // The edge fields of a run item are don't-care, so they carry random bits.
  task automatic run_search();
    offer_item(FUNC_RUN, VTX_W'($urandom_range(0, 63)), VTX_W'($urandom_range(0, 63)),
               WEIGHT_W'($urandom_range(0, 65535)));
  endtask

  // Registers change only with the engine idle: every owed result has come
  // back, and a short pause covers an edge load still being written.
  task automatic wait_until_idle();
    in_valid = 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
    in_valid  = 1'b0;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Weights lean to small values so that paths stay interesting, with the
  // two extremes and fully random patterns mixed in.
  function automatic int pick_weight();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2, 3: return int'($signed(16'($urandom_range(0, 65535))));
      default: return int'($urandom_range(0, 60)) - 20;
    endcase
  endfunction

  initial begin
    int vc;
    int n_eff;
    int start;
    int edges;
    int src;
    int dst;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = FUNC_ADD;
    in_src_vertex = '0;
    in_dst_vertex = '0;
    in_weight     = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_VERTEX_COUNT;
    cfg_wdata     = '0;
    burst_left    = 0;
    items_sent    = 0;
    hold_armed    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings, all 64 vertices: the weight extremes along a path that
    // ends on the top vertex, plus an edge out of a vertex never reached.
    add_edge(0, 1, 32767);
    add_edge(1, 2, -32768);
    add_edge(0, 2, 0);
    add_edge(2, 63, 1);
    add_edge(5, 6, 10);
    run_search();
    // The previous run emptied the store, so this one sees no edges at all.
    run_search();
    wait_until_idle();

    // A vertex count of zero behaves as one; a negative self-loop on the only
    // vertex is seen by the cycle check even though no pass runs.
    write_register(CFG_VERTEX_COUNT, 0);
    add_edge(0, 0, -1);
    run_search();
    wait_until_idle();

    // Counts above the maximum act as the maximum. A negative cycle through
    // the start vertex gives the start vertex itself a predecessor.
    write_register(CFG_VERTEX_COUNT, 127);
    write_register(CFG_START_VERTEX, 63);
    add_edge(63, 0, -3);
    add_edge(0, 63, 2);
    run_search();
    wait_until_idle();

    // A start vertex just past the vertex count leaves everything unreachable.
    write_register(CFG_VERTEX_COUNT, 4);
    write_register(CFG_START_VERTEX, 4);
    add_edge(0, 1, 1);
    run_search();
    wait_until_idle();

    // Edges whose source or destination lies outside the vertex count are
    // ignored, and of two routes to a vertex the cheaper one wins.
    write_register(CFG_VERTEX_COUNT, 3);
    write_register(CFG_START_VERTEX, 2);
    add_edge(2, 0, -7);
    add_edge(0, 5, 1);
    add_edge(9, 1, 1);
    add_edge(0, 1, 100);
    add_edge(2, 1, 50);
    run_search();

    // Random part: each phase picks new settings and then loads and solves a
    // few graphs. Most edges stay inside the vertex count so that the search
    // has real work; the rest have random endpoints.
    hold_armed = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      wait_until_idle();
      case ($urandom_range(0, 9))
        0: vc = 0;
        1: vc = 1;
        2: vc = 64;
        3: vc = $urandom_range(65, 127);
        4: vc = 2;
        default: vc = $urandom_range(2, 8);
      endcase
      n_eff = (vc < 1) ? 1 : (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
      if ($urandom_range(0, 99) < 15) start = $urandom_range(0, 63);
      else start = $urandom_range(0, n_eff - 1);
      // The register ignores bit 6 of the start vertex write, so it is random.
      start = start + 64 * $urandom_range(0, 1);
      if ($urandom_range(0, 1)) begin
        write_register(CFG_VERTEX_COUNT, vc);
        write_register(CFG_START_VERTEX, start);
      end else begin
        write_register(CFG_START_VERTEX, start);
        write_register(CFG_VERTEX_COUNT, vc);
      end
      repeat ($urandom_range(1, 4)) begin
        edges = (n_eff == MAX_VERTICES) ? $urandom_range(0, 6) : $urandom_range(0, 12);
        repeat (edges) begin
          if ($urandom_range(0, 99) < 85) begin
            src = $urandom_range(0, n_eff - 1);
            dst = $urandom_range(0, n_eff - 1);
          end else begin
            src = $urandom_range(0, 63);
            dst = $urandom_range(0, 63);
          end
          add_edge(src, dst, pick_weight());
        end
        run_search();
      end
    end

    wait_until_idle();
    repeat (50) @(negedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("bellman_ford_shortest_path_test OK");
    end else begin
      $display("bellman_ford_shortest_path_test NOT OK");
    end
    $finish;
  end

endmodule
